FILE: src/jsu_pkg.sv
// Shared constants, result codes and queue entry type for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CAP_BITS   = 16;
    localparam int SUM_W      = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 2;

    localparam logic [SUM_W-1:0]    CNT_MAX   = SUM_W'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [CAP_BITS-1:0] CAP_RESET = 16'd64;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNC     = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // One queued item: up to three data bytes, or one status result.
    typedef struct packed {
        logic            kind;
        logic [1:0]      status;
        logic [1:0]      nbytes;
        logic [2:0][7:0] data;
    } jsu_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } jsu_qstat_t;

endpackage

FILE: src/jsu_front.sv
// Decoder front end: escape state machine, capacity check and item build.
`timescale 1ns / 1ps

module jsu_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_begin,
    input  logic [7:0]                in_byte,
    input  logic                      cfg_write,
    input  logic [jsu_pkg::CAP_BITS-1:0] cfg_data,
    input  jsu_pkg::jsu_qstat_t       qstat,
    output logic                      in_ready,
    output logic                      push,
    output jsu_pkg::jsu_item_t        push_item
);
    import jsu_pkg::*;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_BODY = 3'd1;
    localparam logic [2:0] MODE_ESC  = 3'd2;
    localparam logic [2:0] MODE_HEX0 = 3'd3;
    localparam logic [2:0] MODE_HEX1 = 3'd4;
    localparam logic [2:0] MODE_HEX2 = 3'd5;
    localparam logic [2:0] MODE_HEX3 = 3'd6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_QMARK  = 8'h3F;

    logic [2:0]            mode_reg, mode_next;
    logic [15:0]           hex_reg, hex_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  full_reg, full_next;
    logic [CAP_BITS-1:0]   cap_reg;

    logic                  accept;
    logic                  hex_ok;
    logic [3:0]            hex_val;
    logic [15:0]           hex_acc;
    logic [15:0]           cp;
    logic [2:0][7:0]       enc;
    logic [1:0]            enc_len;
    logic                  do_emit;
    logic [SUM_W-1:0]      need;
    logic                  fits;
    jsu_item_t             item;
    logic                  item_valid;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            hex_val = 4'(in_byte - 8'h30);
        end
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
        begin
            hex_val = 4'(in_byte - 8'h57);
        end
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
        begin
            hex_val = 4'(in_byte - 8'h37);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign hex_acc = {hex_reg[11:0], hex_val};

    // Pick the code point to encode: a simple escape or the finished \u value.
    always_comb
    begin
        cp = 16'd0;
        if (mode_reg == MODE_ESC)
        begin
            case (in_byte)
                CH_B:    cp = 16'h0008;
                CH_F:    cp = 16'h000C;
                CH_N:    cp = 16'h000A;
                CH_R:    cp = 16'h000D;
                CH_T:    cp = 16'h0009;
                default: cp = {8'd0, in_byte};
            endcase
        end
        else if (mode_reg == MODE_HEX3)
        begin
            if (hex_acc >= 16'hD800 && hex_acc <= 16'hDFFF)
            begin
                cp = {8'd0, CH_QMARK};
            end
            else
            begin
                cp = hex_acc;
            end
        end
        else
        begin
            cp = {8'd0, in_byte};
        end
    end

    // Raw bytes in the string body pass through as they are, never re-encoded.
    always_comb
    begin
        enc = '0;
        if (mode_reg == MODE_BODY)
        begin
            enc[0]  = in_byte;
            enc_len = 2'd1;
        end
        else if (cp < 16'h0080)
        begin
            enc[0]  = cp[7:0];
            enc_len = 2'd1;
        end
        else if (cp < 16'h0800)
        begin
            enc[0]  = 8'hC0 | {3'd0, cp[10:6]};
            enc[1]  = 8'h80 | {2'd0, cp[5:0]};
            enc_len = 2'd2;
        end
        else
        begin
            enc[0]  = 8'hE0 | {4'd0, cp[15:12]};
            enc[1]  = 8'h80 | {2'd0, cp[11:6]};
            enc[2]  = 8'h80 | {2'd0, cp[5:0]};
            enc_len = 2'd3;
        end
    end

    assign need = SUM_W'(count_reg) + SUM_W'(enc_len);
    assign fits = ((need + SUM_W'(1)) <= SUM_W'(cap_reg)) && (need <= CNT_MAX);

    always_comb
    begin
        mode_next   = mode_reg;
        hex_next    = hex_reg;
        count_next  = count_reg;
        full_next   = full_reg;
        do_emit     = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        item.kind   = KIND_STATUS;
        item.nbytes = 2'd1;

        if (in_begin)
        begin
            hex_next   = 16'd0;
            count_next = '0;
            full_next  = 1'b0;
            if (in_byte != CH_QUOTE || cap_reg == '0)
            begin
                item_valid  = 1'b1;
                item.status = ST_MALFORMED;
                mode_next   = MODE_IDLE;
            end
            else
            begin
                mode_next = MODE_BODY;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_BODY:
                begin
                    if (in_byte == 8'd0)
                    begin
                        item_valid  = 1'b1;
                        item.status = ST_MALFORMED;
                        mode_next   = MODE_IDLE;
                    end
                    else if (in_byte == CH_QUOTE)
                    begin
                        item_valid  = 1'b1;
                        item.status = full_reg ? ST_TRUNC : ST_OK;
                        mode_next   = MODE_IDLE;
                    end
                    else if (in_byte == CH_BSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        do_emit = 1'b1;
                    end
                end
                MODE_ESC:
                begin
                    if (in_byte == CH_U)
                    begin
                        hex_next  = 16'd0;
                        mode_next = MODE_HEX0;
                    end
                    else if (in_byte == CH_QUOTE || in_byte == CH_BSLASH ||
                             in_byte == CH_SLASH || in_byte == CH_B ||
                             in_byte == CH_F || in_byte == CH_N ||
                             in_byte == CH_R || in_byte == CH_T)
                    begin
                        mode_next = MODE_BODY;
                        do_emit   = 1'b1;
                    end
                    else
                    begin
                        item_valid  = 1'b1;
                        item.status = ST_MALFORMED;
                        mode_next   = MODE_IDLE;
                    end
                end
                MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3:
                begin
                    if (!hex_ok)
                    begin
                        item_valid  = 1'b1;
                        item.status = ST_MALFORMED;
                        mode_next   = MODE_IDLE;
                    end
                    else
                    begin
                        hex_next = hex_acc;
                        if (mode_reg == MODE_HEX3)
                        begin
                            mode_next = MODE_BODY;
                            do_emit   = 1'b1;
                        end
                        else
                        begin
                            mode_next = mode_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end

        // Once one item has missed, drop the rest but keep scanning.
        if (do_emit && !full_reg)
        begin
            if (fits)
            begin
                item_valid  = 1'b1;
                item.kind   = KIND_DATA;
                item.nbytes = enc_len;
                item.data   = enc;
                count_next  = need[COUNT_BITS-1:0];
            end
            else
            begin
                full_next = 1'b1;
            end
        end
    end

    assign push      = accept && item_valid;
    assign push_item = item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            hex_reg   <= 16'd0;
            count_reg <= '0;
            full_reg  <= 1'b0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            if (accept)
            begin
                mode_reg  <= mode_next;
                hex_reg   <= hex_next;
                count_reg <= count_next;
                full_reg  <= full_next;
            end
            if (cfg_write)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

endmodule

FILE: src/jsu_fifo.sv
// Short item queue between the decoder and the output serializer.
`timescale 1ns / 1ps

module jsu_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  jsu_pkg::jsu_item_t  push_item,
    input  logic                pop,
    output jsu_pkg::jsu_item_t  head,
    output jsu_pkg::jsu_qstat_t qstat
);
    import jsu_pkg::*;

    jsu_item_t         mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push, do_pop;

    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QDEPTH))
        else $error("queue count exceeds depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == (QPTR_W + 1)'(QDEPTH)) |->
        (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

FILE: src/jsu_back.sv
// Output serializer: splits queued items into single results behind an output register.
`timescale 1ns / 1ps

module jsu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  jsu_pkg::jsu_item_t  head,
    input  jsu_pkg::jsu_qstat_t qstat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_kind,
    output logic [7:0]          out_byte,
    output logic [1:0]          out_status,
    output logic                out_last
);
    import jsu_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic [1:0] status_reg;
    logic       last_reg;
    logic       load;
    logic       final_el;

    assign load     = (!valid_reg || out_ready) && !qstat.empty;
    assign final_el = (idx_reg == head.nbytes - 2'd1) || (head.kind == KIND_STATUS);
    assign pop      = load && final_el;
    assign idx_next = pop ? 2'd0 : (load ? idx_reg + 2'd1 : idx_reg);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= head.kind;
            byte_reg   <= (head.kind == KIND_DATA) ? head.data[idx_reg] : 8'd0;
            status_reg <= (head.kind == KIND_STATUS) ? head.status : ST_OK;
            last_reg   <= final_el;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = valid_reg;
    assign out_kind   = kind_reg;
    assign out_byte   = byte_reg;
    assign out_status = status_reg;
    assign out_last   = last_reg;

`ifndef SYNTH
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == KIND_STATUS) |-> (last_reg && byte_reg == 8'd0))
        else $error("status result without last or with data");
    a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == KIND_DATA) |-> (status_reg == ST_OK))
        else $error("data result carries a status");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!qstat.empty && head.kind == KIND_DATA) |->
        (head.nbytes != 2'd0 && idx_reg < head.nbytes))
        else $error("byte index beyond item length");
    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.empty |-> (idx_reg == 2'd0))
        else $error("byte index not cleared with empty queue");
`endif

endmodule

FILE: src/json_string_unescape.sv
// Top level of the streaming JSON string unescaper.
//
// Input stream (s_*): one byte of a quoted JSON string per transfer; s_tuser
// marks the opening quote and restarts decoding. Output stream (m_*): one
// result per transfer, either a decoded UTF-8 byte (m_tuser = 0) or the final
// status (m_tuser = 1: 0 ok, 1 truncated, 2 malformed). m_tlast flags the last
// result caused by an input byte. cfg_* writes the output capacity in bytes
// (terminator byte included, reset value 64); write it only while idle.
// Throughput: one input byte per cycle while the queue is not full; a \uXXXX
// escape yields up to three results, which drain one per cycle while m_tready
// is high, from a four-entry item queue. Results pass the queue, then the
// output register. The front decoder stalls s_tready only when the queue is
// full, so a stalled receiver backs up the output register, then the queue,
// then the input. Reset clears the decoder to idle, empties the queue and
// drops any pending output; bytes before the next opening quote are ignored.
`timescale 1ns / 1ps

module json_string_unescape (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] begin_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] status, [15:10] zero
    output logic        m_tuser,   // [0] result_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // out_capacity
);
    import jsu_pkg::*;

    jsu_item_t  push_item;
    jsu_item_t  head;
    jsu_qstat_t qstat;
    logic       push;
    logic       pop;
    logic [7:0] out_byte;
    logic [1:0] out_status;

    assign cfg_ready = 1'b1;

    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_begin  (s_tuser),
        .in_byte   (s_tdata),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .qstat     (qstat),
        .in_ready  (s_tready),
        .push      (push),
        .push_item (push_item)
    );

    jsu_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_byte   (out_byte),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    assign m_tdata = {6'd0, out_status, out_byte};

endmodule

FILE: bench/jsu_chars_pkg.sv
// Character codes shared by the unescaper bench stimulus and its checker.
`timescale 1ns / 1ps

package jsu_chars_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = "\"";
    localparam logic [7:0] CH_BSLASH = "\\";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_NINE   = "9";
    localparam logic [7:0] CH_UP_A   = "A";
    localparam logic [7:0] CH_UP_F   = "F";
    localparam logic [7:0] CH_LOW_A  = "a";
    localparam logic [7:0] CH_LOW_B  = "b";
    localparam logic [7:0] CH_LOW_F  = "f";
    localparam logic [7:0] CH_LOW_N  = "n";
    localparam logic [7:0] CH_LOW_R  = "r";
    localparam logic [7:0] CH_LOW_T  = "t";
    localparam logic [7:0] CH_LOW_U  = "u";

    // Letters that follow a backslash in a single-character escape, quote at index 0.
    localparam logic [7:0][7:0] SIMPLE_ESCAPES = {CH_LOW_T, CH_LOW_R, CH_LOW_N, CH_LOW_F,
                                                  CH_LOW_B, CH_SLASH, CH_BSLASH, CH_QUOTE};

    // Surrogate range of \u code points, replaced by '?' on output.
    localparam logic [15:0] SURR_LOW  = 16'hD800;
    localparam logic [15:0] SURR_HIGH = 16'hDFFF;
    localparam logic [7:0]  CH_QMARK  = "?";

endpackage

FILE: bench/unescape_checker.sv
// Checker that predicts the unescaper output from observed transfers and compares it.
`timescale 1ns / 1ps

module unescape_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    import jsu_pkg::*;
    import jsu_chars_pkg::*;

    typedef enum logic [2:0] {
        DEC_IDLE,
        DEC_BODY,
        DEC_ESC,
        DEC_HEX1,
        DEC_HEX2,
        DEC_HEX3,
        DEC_HEX4
    } dec_mode_e;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } decoded_t;

    decoded_t                predicted_out[$];
    logic [CAP_BITS-1:0]     capacity;
    dec_mode_e               mode;
    logic [15:0]             hex_acc;
    logic [COUNT_BITS-1:0]   emitted;
    logic                    full;

    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_LOW_A && c <= CH_LOW_F)
            return int'(c - CH_LOW_A) + 10;
        if (c >= CH_UP_A && c <= CH_UP_F)
            return int'(c - CH_UP_A) + 10;
        return -1;
    endfunction

    task automatic finish_string(input logic [1:0] st);
        predicted_out.push_back('{KIND_STATUS, 8'h00, st, 1'b1});
        mode = DEC_IDLE;
    endtask

    // An item goes out whole or not at all; one that does not fit stops all further data bytes of the string.
    task automatic emit_bytes(input logic [2:0][7:0] b, input int len);
        longint need;
        int     i;
        if (full)
            return;
        need = longint'(emitted) + len;
        if (need + 1 > longint'(capacity) || need > (longint'(1) << COUNT_BITS) - 1) begin
            full = 1'b1;
            return;
        end
        for (i = 0; i < len; i++)
            predicted_out.push_back('{KIND_DATA, b[i], ST_OK, (i == len - 1)});
        emitted = need[COUNT_BITS-1:0];
    endtask

    task automatic encode_utf8(input logic [15:0] cp);
        logic [2:0][7:0] b;
        b = '0;
        if (cp < 16'h0080) begin
            b[0] = cp[7:0];
            emit_bytes(b, 1);
        end
        else if (cp < 16'h0800) begin
            b[0] = 8'hC0 | {3'd0, cp[10:6]};
            b[1] = 8'h80 | {2'd0, cp[5:0]};
            emit_bytes(b, 2);
        end
        else begin
            b[0] = 8'hE0 | {4'd0, cp[15:12]};
            b[1] = 8'h80 | {2'd0, cp[11:6]};
            b[2] = 8'h80 | {2'd0, cp[5:0]};
            emit_bytes(b, 3);
        end
    endtask

    task automatic unescape_step(input logic first, input logic [7:0] c);
        logic [15:0]     cp;
        logic            decoded;
        logic [2:0][7:0] raw;
        int              h;
        if (first) begin
            hex_acc = '0;
            emitted = '0;
            full    = 1'b0;
            if (c != CH_QUOTE || capacity == 0)
                finish_string(ST_MALFORMED);
            else
                mode = DEC_BODY;
            return;
        end
        case (mode)
            DEC_BODY: begin
                if (c == CH_NUL)
                    finish_string(ST_MALFORMED);
                else if (c == CH_QUOTE)
                    finish_string(full ? ST_TRUNC : ST_OK);
                else if (c == CH_BSLASH)
                    mode = DEC_ESC;
                else begin
                    raw    = '0;
                    raw[0] = c;
                    emit_bytes(raw, 1);
                end
            end
            DEC_ESC: begin
                decoded = 1'b1;
                cp      = {8'h00, c};
                case (c)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: ;
                    CH_LOW_B: cp = 16'h0008;
                    CH_LOW_F: cp = 16'h000C;
                    CH_LOW_N: cp = 16'h000A;
                    CH_LOW_R: cp = 16'h000D;
                    CH_LOW_T: cp = 16'h0009;
                    CH_LOW_U: begin
                        hex_acc = '0;
                        mode    = DEC_HEX1;
                        decoded = 1'b0;
                    end
                    default: begin
                        finish_string(ST_MALFORMED);
                        decoded = 1'b0;
                    end
                endcase
                if (decoded) begin
                    mode = DEC_BODY;
                    encode_utf8(cp);
                end
            end
            DEC_HEX1, DEC_HEX2, DEC_HEX3, DEC_HEX4: begin
                h = hex_value(c);
                if (h < 0)
                    finish_string(ST_MALFORMED);
                else begin
                    hex_acc = {hex_acc[11:0], 4'(h)};
                    if (mode != DEC_HEX4)
                        mode = dec_mode_e'(mode + 3'd1);
                    else begin
                        mode = DEC_BODY;
                        cp   = hex_acc;
                        if (cp >= SURR_LOW && cp <= SURR_HIGH)
                            cp = {8'h00, CH_QMARK};
                        encode_utf8(cp);
                    end
                end
            end
            default: mode = DEC_IDLE;
        endcase
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        decoded_t got;
        decoded_t want;
        got = '{m_tuser, m_tdata[7:0], m_tdata[9:8], m_tlast};
        if (predicted_out.size() == 0) begin
            $error("result with nothing expected: kind %0d byte 0x%0h status %0d last %0d",
                   got.kind, got.data, got.status, got.last);
            fail_count++;
            return;
        end
        want = predicted_out.pop_front();
        compare_field("result_kind", int'(want.kind), int'(got.kind));
        compare_field("out_byte", int'(want.data), int'(got.data));
        compare_field("status", int'(want.status), int'(got.status));
        compare_field("last", int'(want.last), int'(got.last));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            predicted_out.delete();
            capacity   = CAP_RESET;
            mode       = DEC_IDLE;
            hex_acc    = '0;
            emitted    = '0;
            full       = 1'b0;
            fail_count = 0;
            pending    = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (s_tvalid && s_tready)
                unescape_step(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                check_result();
            pending = predicted_out.size();
        end
    end

endmodule

FILE: bench/testbench.sv
// Top of the unescaper bench: clock, reset, stimulus, receiver, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;

    import jsu_chars_pkg::*;

    localparam int ITEM_TARGET    = 430;
    localparam int N_PHASES       = 6;
    localparam int DRAIN_CYCLES   = 12;
    localparam int LONG_STALL     = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [7:0][15:0] EDGE_CODE_POINTS = {16'hFFFF, 16'hE000, 16'hD7FF, 16'h0800,
                                                     16'h07FF, 16'h0080, 16'h007F, 16'h0000};

    typedef enum int {
        FLT_NONE,
        FLT_NUL,
        FLT_BAD_ESCAPE,
        FLT_BAD_HEX,
        FLT_RESTART,
        FLT_NO_QUOTE,
        FLT_UNTERMINATED
    } fault_e;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    int          fail_count;
    int          pending;
    int          sent_bytes;
    int          quiet_cycles;
    logic [15:0] cur_capacity;
    bit          stall_request;
    int          tx_run_left;
    bit          tx_no_idle;

    json_string_unescape dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    unescape_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle gaps come in runs: some runs never idle, the rest draw 0..16 per transfer.
    function automatic int draw_gap(inout int run_left, inout bit no_idle);
        if (run_left == 0) begin
            run_left = $urandom_range(8, 40);
            no_idle  = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [7:0] raw_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return CH_ZERO + 8'(n);
        return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] bad_escape();
        case ($urandom_range(0, 4))
            0:       return "a";
            1:       return "U";
            2:       return 8'($urandom_range(8'h80, 8'hFF));
            3:       return CH_ZERO + 8'($urandom_range(0, 9));
            default: return CH_NUL;
        endcase
    endfunction

    function automatic logic [7:0] bad_hex();
        case ($urandom_range(0, 4))
            0:       return 8'($urandom_range("g", "z"));
            1:       return 8'($urandom_range("G", "Z"));
            2:       return 8'($urandom_range(8'h80, 8'hFF));
            3:       return 8'($urandom_range(8'h00, 8'h2F));
            default: return 8'($urandom_range(8'h3A, 8'h40));
        endcase
    endfunction

    function automatic logic [15:0] pick_code_point();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(16'h0000, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hFFFF));
            3:       return 16'($urandom_range(SURR_LOW, SURR_HIGH));
            default: return EDGE_CODE_POINTS[$urandom_range(0, 7)];
        endcase
    endfunction

    // Valid stays high from one transfer to the next unless a gap is drawn.
    task automatic send_byte(input bit first, input logic [7:0] c, input bit counted);
        int gap;
        gap = draw_gap(tx_run_left, tx_no_idle);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        if (counted)
            sent_bytes++;
    endtask

    task automatic send_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            send_byte(1'b0, text[i], 1'b1);
    endtask

    task automatic send_unicode(input logic [15:0] cp);
        int k;
        send_byte(1'b0, CH_BSLASH, 1'b1);
        send_byte(1'b0, CH_LOW_U, 1'b1);
        for (k = 3; k >= 0; k--)
            send_byte(1'b0, hex_char(cp[k*4 +: 4]), 1'b1);
    endtask

    task automatic send_item();
        case ($urandom_range(0, 5))
            0, 1, 2: send_byte(1'b0, raw_byte(), 1'b1);
            3: begin
                send_byte(1'b0, CH_BSLASH, 1'b1);
                send_byte(1'b0, SIMPLE_ESCAPES[$urandom_range(0, 7)], 1'b1);
            end
            default: send_unicode(pick_code_point());
        endcase
    endtask

    // One quoted string with random content; some get a fault at a random position.
    task automatic send_string();
        int         n_items;
        int         fault_at;
        int         i;
        fault_e     fault;
        logic [7:0] c;
        n_items  = $urandom_range(0, 10);
        fault_at = $urandom_range(0, n_items);
        fault    = ($urandom_range(0, 5) == 0) ? fault_e'($urandom_range(1, 6)) : FLT_NONE;
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b0);
        if (fault == FLT_NO_QUOTE) begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == CH_QUOTE);
            send_byte(1'b1, c, 1'b1);
            repeat ($urandom_range(0, 2)) send_byte(1'b0, raw_byte(), 1'b0);
            return;
        end
        send_byte(1'b1, CH_QUOTE, 1'b1);
        if (cur_capacity == 0) begin
            send_byte(1'b0, raw_byte(), 1'b0);
            return;
        end
        for (i = 0; i <= n_items; i++) begin
            if (i == fault_at) begin
                case (fault)
                    FLT_NUL: begin
                        send_byte(1'b0, CH_NUL, 1'b1);
                        return;
                    end
                    FLT_BAD_ESCAPE: begin
                        send_byte(1'b0, CH_BSLASH, 1'b1);
                        send_byte(1'b0, bad_escape(), 1'b1);
                        return;
                    end
                    FLT_BAD_HEX: begin
                        send_byte(1'b0, CH_BSLASH, 1'b1);
                        send_byte(1'b0, CH_LOW_U, 1'b1);
                        repeat ($urandom_range(0, 3))
                            send_byte(1'b0, hex_char(4'($urandom_range(0, 15))), 1'b1);
                        send_byte(1'b0, bad_hex(), 1'b1);
                        return;
                    end
                    FLT_RESTART: send_byte(1'b1, CH_QUOTE, 1'b1);
                    default: ;
                endcase
            end
            if (i < n_items)
                send_item();
        end
        if (fault != FLT_UNTERMINATED)
            send_byte(1'b0, CH_QUOTE, 1'b1);
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline settle.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_capacity = value;
    endtask

    initial
    begin : stimulus
        int          p;
        int          base;
        logic [15:0] cap;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        sent_bytes    = 0;
        stall_request = 1'b0;
        tx_run_left   = 0;
        tx_no_idle    = 1'b0;
        cur_capacity  = jsu_pkg::CAP_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset capacity.
        send_byte(1'b0, "A", 1'b0);              // no open string: ignored
        send_byte(1'b1, CH_NUL, 1'b1);           // begin on a byte other than the quote
        send_byte(1'b1, CH_QUOTE, 1'b1);
        send_byte(1'b0, 8'hFF, 1'b1);
        send_text("\\t\\u07FF\\uFFff\\udF00\"");
        send_byte(1'b1, CH_QUOTE, 1'b1);
        send_byte(1'b1, CH_QUOTE, 1'b1);         // restart inside an open string
        send_text("\\u0g");
        send_byte(1'b1, CH_QUOTE, 1'b1);
        send_text("\\q");
        send_byte(1'b1, CH_QUOTE, 1'b1);
        send_byte(1'b0, CH_NUL, 1'b1);

        // Random part, one capacity per phase.
        base = sent_bytes;
        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       cap = 16'd0;
                1:       cap = 16'd1;
                2:       cap = 16'($urandom_range(2, 6));
                3:       cap = 16'hFFFF;
                4:       cap = 16'($urandom_range(7, 80));
                default: cap = 16'($urandom_range(0, 16'hFFFF));
            endcase
            wait_idle();
            write_capacity(cap);
            if (p == 3)
                stall_request = 1'b1;
            while (sent_bytes < base + (p + 1) * ITEM_TARGET / N_PHASES)
                send_string();
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : result_sink
        int gap;
        int rx_run_left;
        bit rx_no_idle;
        m_tready    = 1'b0;
        rx_run_left = 0;
        rx_no_idle  = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (stall_request) begin
                // Hold off long enough for the block to back up into its input.
                stall_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(negedge clk);
            end
            else begin
                gap = draw_gap(rx_run_left, rx_no_idle);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
